// ===== src/nibble_rle_encoder_assert.svh =====
// Assertion macros used by the run-length encoder datapath.
// Each macro takes a label, the clock, the active-low reset, a condition
// and a consequence.
`ifndef NIBBLE_RLE_ENCODER_ASSERT_SVH
`define NIBBLE_RLE_ENCODER_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define NRE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("nibble_rle_encoder: assertion failed");
// Next-cycle implication.
`define NRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nibble_rle_encoder: assertion failed");
`else
`define NRE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define NRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/nre_pkg.sv =====
`default_nettype none

package nre_pkg;

	// Window of pixels that are not yet coded, and the longest group.
	localparam logic [3:0] WIN_DEPTH = 4'd9;
	localparam logic [3:0] MAX_GROUP = 4'd8;
	// A literal group of n pixels is headed by the nibble 16-n.
	localparam logic [4:0] LIT_BIAS = 5'd16;

	// One input word: a pixel and its end-of-bitmap flag.
	typedef struct packed {
		logic [3:0] pixel;
		logic       final_pixel;
	} pix_word_t;

	// One output word: two packed code nibbles and the last-byte flag.
	typedef struct packed {
		logic [7:0] code_byte;
		logic       final_byte;
	} code_word_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_EMIT,
		ST_FLUSH,
		ST_FINISH
	} nre_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic latch;
		logic put_nib;
		logic flush;
		logic finish;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic decided;
		logic at_end;
		logic nib_last;
		logic slot_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== src/nre_ctrl.sv =====
`default_nettype none

module nre_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              pix_valid,
	output logic                   pix_stall,
	input  wire nre_pkg::dp_status_t status,
	output nre_pkg::ctl_cmd_t      cmd
);

	nre_pkg::nre_state_t state_q;
	nre_pkg::nre_state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nre_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		pix_stall = 1'b1;
		case (state_q)
			nre_pkg::ST_IDLE: begin
				pix_stall = 1'b0;
				if (pix_valid) begin
					cmd.load = 1'b1;
					state_d  = nre_pkg::ST_EVAL;
				end
			end
			nre_pkg::ST_EVAL: begin
				// Look at the window front and capture the group, if any.
				cmd.latch = 1'b1;
				if (status.decided) begin
					state_d = nre_pkg::ST_EMIT;
				end else if (status.at_end) begin
					state_d = nre_pkg::ST_FLUSH;
				end else begin
					state_d = nre_pkg::ST_IDLE;
				end
			end
			nre_pkg::ST_EMIT: begin
				// One code nibble per cycle while the output slot is free.
				if (status.slot_free) begin
					cmd.put_nib = 1'b1;
					if (status.nib_last) begin
						state_d = nre_pkg::ST_EVAL;
					end
				end
			end
			nre_pkg::ST_FLUSH: begin
				if (status.slot_free) begin
					cmd.flush = 1'b1;
					state_d   = nre_pkg::ST_FINISH;
				end
			end
			nre_pkg::ST_FINISH: begin
				if (status.slot_free) begin
					cmd.finish = 1'b1;
					state_d    = nre_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nre_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== src/nre_datapath.sv =====
`default_nettype none

`include "nibble_rle_encoder_assert.svh"

module nre_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire nre_pkg::ctl_cmd_t  cmd,
	output nre_pkg::dp_status_t     status,
	input  wire nre_pkg::pix_word_t pix_word,
	input  wire logic               code_stall,
	output logic                    code_valid,
	output nre_pkg::code_word_t     code_word
);

	logic [3:0]          win_q [nre_pkg::WIN_DEPTH];
	logic [3:0]          count_q;
	logic [3:0]          held_q;
	logic                phase_q;
	logic                at_end_q;
	logic [3:0]          grp_len_q;
	logic                grp_run_q;
	logic [3:0]          idx_q;
	logic                pend_valid_q;
	logic [7:0]          pend_byte_q;
	logic                out_valid_q;
	nre_pkg::code_word_t out_q;

	logic [3:0]          run_len;
	logic [3:0]          lit_len;
	logic                decided;
	logic                grp_run;
	logic [3:0]          grp_len;
	logic [3:0]          nib;
	logic                nib_last;
	logic                slot_free;
	logic                push;
	logic [7:0]          new_byte;
	logic                send_en;
	nre_pkg::code_word_t send_word;

	// Length of the run at the window front and of a literal group there.
	always_comb begin
		logic run_go;
		logic lit_found;
		run_go    = 1'b1;
		lit_found = 1'b0;
		run_len   = 4'd1;
		lit_len   = nre_pkg::MAX_GROUP;
		for (int j = 1; j < nre_pkg::MAX_GROUP; j++) begin
			if (run_go && (4'(j) < count_q) && (win_q[j] == win_q[0])) begin
				run_len = run_len + 4'd1;
			end else begin
				run_go = 1'b0;
			end
		end
		for (int j = 0; j < nre_pkg::MAX_GROUP; j++) begin
			if (!lit_found && ((4'(j + 1) >= count_q) || (win_q[j] == win_q[j + 1]))) begin
				lit_len   = 4'(j);
				lit_found = 1'b1;
			end
		end
	end

	// Decide whether the front group is certain in kind and length.
	always_comb begin
		decided = 1'b0;
		grp_run = 1'b0;
		grp_len = run_len;
		if (count_q == 4'd0) begin
			decided = 1'b0;
		end else if (run_len >= 4'd2) begin
			grp_run = 1'b1;
			decided = (run_len == nre_pkg::MAX_GROUP) || (run_len < count_q) || at_end_q;
		end else if ((count_q == 4'd1) && !at_end_q) begin
			decided = 1'b0;
		end else if (((lit_len + 4'd1) < count_q) || (lit_len == nre_pkg::MAX_GROUP)) begin
			decided = 1'b1;
			grp_len = lit_len;
		end else if (at_end_q) begin
			decided = 1'b1;
			grp_len = count_q;
		end
	end

	// Code nibble at the current emit position: header first, then pixels.
	always_comb begin
		if (idx_q == 4'd0) begin
			if (grp_run_q) begin
				nib = grp_len_q - 4'd1;
			end else begin
				nib = 4'(nre_pkg::LIT_BIAS - {1'b0, grp_len_q});
			end
		end else if (grp_run_q) begin
			nib = win_q[0];
		end else begin
			nib = win_q[idx_q - 4'd1];
		end
		nib_last = grp_run_q ? (idx_q == 4'd1) : (idx_q == grp_len_q);
	end

	// Byte packing. In the last step of a bitmap the newest byte waits so
	// that it can carry the end flag.
	always_comb begin
		slot_free = !out_valid_q || !code_stall;
		push      = 1'b0;
		new_byte  = {4'd0, held_q};
		send_en   = 1'b0;
		send_word = '0;
		if (cmd.put_nib && phase_q) begin
			push     = 1'b1;
			new_byte = {nib, held_q};
		end else if (cmd.flush && phase_q) begin
			push     = 1'b1;
			new_byte = {4'd0, held_q};
		end
		if (push && !at_end_q) begin
			send_en             = 1'b1;
			send_word.code_byte = new_byte;
		end else if (push && pend_valid_q) begin
			send_en             = 1'b1;
			send_word.code_byte = pend_byte_q;
		end else if (cmd.finish && pend_valid_q) begin
			send_en              = 1'b1;
			send_word.code_byte  = pend_byte_q;
			send_word.final_byte = 1'b1;
		end
	end

	// Window storage: append on load, drop the coded group after its last nibble.
	always_ff @(posedge clk) begin
		if (cmd.load && (count_q < nre_pkg::WIN_DEPTH)) begin
			win_q[count_q] <= pix_word.pixel;
		end else if (cmd.put_nib && nib_last) begin
			for (int i = 0; i < nre_pkg::WIN_DEPTH; i++) begin
				logic [4:0] src;
				src = 5'(i) + {1'b0, grp_len_q};
				if (src < {1'b0, nre_pkg::WIN_DEPTH}) begin
					win_q[i] <= win_q[src[3:0]];
				end
			end
		end
	end

	// Group capture, emit position and nibble pairing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			held_q    <= '0;
			phase_q   <= 1'b0;
			at_end_q  <= 1'b0;
			grp_len_q <= '0;
			grp_run_q <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (cmd.load) begin
				at_end_q <= pix_word.final_pixel;
				if (count_q < nre_pkg::WIN_DEPTH) begin
					count_q <= count_q + 4'd1;
				end
			end
			if (cmd.latch) begin
				grp_len_q <= grp_len;
				grp_run_q <= grp_run;
				idx_q     <= '0;
			end
			if (cmd.put_nib) begin
				if (phase_q) begin
					held_q  <= '0;
					phase_q <= 1'b0;
				end else begin
					held_q  <= nib;
					phase_q <= 1'b1;
				end
				if (nib_last) begin
					idx_q   <= '0;
					count_q <= count_q - grp_len_q;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
			if (cmd.flush) begin
				held_q  <= '0;
				phase_q <= 1'b0;
			end
			if (cmd.finish) begin
				count_q  <= '0;
				held_q   <= '0;
				phase_q  <= 1'b0;
				at_end_q <= 1'b0;
			end
		end
	end

	// Held byte of the last step and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push && at_end_q) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				pend_valid_q <= 1'b0;
			end
			if (send_en) begin
				out_valid_q <= 1'b1;
			end else if (!code_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (push && at_end_q) begin
			pend_byte_q <= new_byte;
		end
		if (send_en) begin
			out_q <= send_word;
		end
	end

	assign status.decided   = decided;
	assign status.at_end    = at_end_q;
	assign status.nib_last  = nib_last;
	assign status.slot_free = slot_free;
	assign code_valid       = out_valid_q;
	assign code_word        = out_q;

	// The window never holds more than its depth.
	`NRE_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= nre_pkg::WIN_DEPTH)
	// The end of a bitmap leaves no pixel, nibble or byte behind.
	`NRE_ASSERT_NEXT(a_finish_clears, clk, arst_n, cmd.finish, (count_q == 4'd0) && !phase_q && !pend_valid_q)
	// A byte is held back only in the last step of a bitmap.
	`NRE_ASSERT_IMPL(a_pend_at_end, clk, arst_n, pend_valid_q, at_end_q)
	// A word is only written into a free output register.
	`NRE_ASSERT_IMPL(a_send_slot, clk, arst_n, send_en, slot_free)
	// A decided group has one to eight pixels.
	`NRE_ASSERT_NEXT(a_group_len, clk, arst_n, cmd.latch && decided, (grp_len_q != 4'd0) && (grp_len_q <= nre_pkg::MAX_GROUP))

endmodule

`default_nettype wire

// ===== src/nibble_rle_encoder.sv =====
// Run-length encoder for a stream of 4-bit pixels with nibble codes.
// Input channel pix_*: one pixel word per handshake (pix_valid high and
// pix_stall low), the last pixel of a bitmap flagged by final_pixel.
// Output channel code_*: one code byte per word, the first code nibble in
// bits 3..0, final_byte set on the last byte of the bitmap.
// A pixel is taken in ST_IDLE and the window front is then looked at in
// ST_EVAL. Each group that the pixel completes is put out in ST_EMIT, one
// code nibble per cycle while the output slot is free, and the window is
// looked at again in ST_EVAL. The last pixel of a bitmap then passes through
// ST_FLUSH to flush the odd nibble and ST_FINISH to flag the final byte. The
// nibble-serial packing path limits the throughput; pix_stall is high while
// an item is at work, so no new pixel is taken until the last is through.
// A code byte is written into the output register when the second nibble of
// a pair is put out. On the last item of a bitmap each byte is held back one
// byte so that the newest can carry the end flag, and the final byte is
// written in ST_FINISH.
// Reset clears the window, the nibble pairing and the output register; no
// word is offered after reset until pixels arrive.
// While code_stall is high and a word is offered, the output word holds and
// the encoder waits for the register to drain before it writes the next code nibble.
`default_nettype none

module nibble_rle_encoder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pix_valid,
	output logic                    pix_stall,
	input  wire nre_pkg::pix_word_t pix_word,
	output logic                    code_valid,
	input  wire logic               code_stall,
	output nre_pkg::code_word_t     code_word
);

	nre_pkg::ctl_cmd_t   cmd;
	nre_pkg::dp_status_t status;

	// Sequencer for loading, group decisions and flushing.
	nre_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Pixel window, group coder and byte packer.
	nre_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.pix_word   (pix_word),
		.code_stall (code_stall),
		.code_valid (code_valid),
		.code_word  (code_word)
	);

endmodule

`default_nettype wire
